FILE: sv/round_robin_run_queue_macros.svh
// Assertion macros for the run queue controller.
`ifndef ROUND_ROBIN_RUN_QUEUE_MACROS_SVH
`define ROUND_ROBIN_RUN_QUEUE_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define RRQ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checks that a condition never holds outside of reset.
`define RRQ_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

FILE: sv/rrq_pkg.sv
`timescale 1ns / 1ps
package rrq_pkg;

   localparam int RRQ_QUEUE_DEPTH = 16;
   localparam int RRQ_ID_BITS     = 15;

   typedef enum logic [1:0] {
      OP_ADD     = 2'd0,
      OP_PICK    = 2'd1,
      OP_LOOKUP  = 2'd2,
      OP_UNREADY = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD,
      S_DROP,
      S_SCAN,
      S_DONE
   } state_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_WRITE,
      CELL_SHIFT,
      CELL_ROTATE,
      CELL_ROTATE_CLR
   } cell_op_type;

endpackage

FILE: sv/rrq_cell.sv
`timescale 1ns / 1ps
module rrq_cell import rrq_pkg::*; #(
   parameter int ID_BITS = RRQ_ID_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  cell_op_type        cell_op,
   input  logic               sel_write,
   input  logic               sel_last,
   input  logic [ID_BITS-1:0] write_id,
   input  logic [ID_BITS-1:0] next_id,
   input  logic               next_ready,
   input  logic [ID_BITS-1:0] head_id,
   input  logic               head_ready,
   output logic [ID_BITS-1:0] id_out,
   output logic               ready_out
);

   logic [ID_BITS-1:0] id_ff, id_in;
   logic               ready_ff, ready_in;

   always_comb begin
      id_in    = id_ff;
      ready_in = ready_ff;
      case (cell_op)
         CELL_WRITE: begin
            if (sel_write) begin
               id_in    = write_id;
               ready_in = 1'b1;
            end
         end
         CELL_SHIFT: begin
            id_in    = next_id;
            ready_in = next_ready;
         end
         CELL_ROTATE: begin
            id_in    = sel_last ? head_id : next_id;
            ready_in = sel_last ? head_ready : next_ready;
         end
         CELL_ROTATE_CLR: begin
            id_in    = sel_last ? head_id : next_id;
            ready_in = sel_last ? 1'b0 : next_ready;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
      if (reset) begin
         ready_ff <= 1'b0;
      end else begin
         ready_ff <= ready_in;
      end
   end

   assign id_out    = id_ff;
   assign ready_out = ready_ff;

endmodule

FILE: sv/rrq_ctrl.sv
`timescale 1ns / 1ps
`include "round_robin_run_queue_macros.svh"
module rrq_ctrl import rrq_pkg::*; #(
   parameter int QUEUE_DEPTH = RRQ_QUEUE_DEPTH,
   parameter int ID_BITS     = RRQ_ID_BITS,
   localparam int CW         = $clog2(QUEUE_DEPTH + 1),
   localparam int IN_W       = ((2 + ID_BITS + 7) / 8) * 8,
   localparam int OUT_W      = ((ID_BITS + 4 + 7) / 8) * 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [IN_W-1:0]    req_tdata,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [OUT_W-1:0]   rsp_tdata,
   input  logic [ID_BITS-1:0] head_id,
   input  logic               head_ready,
   output cell_op_type        cell_op,
   output logic [CW-1:0]      entry_count,
   output logic [ID_BITS-1:0] write_id
);

   state_type          state_ff, state_in;
   op_type             op_ff, op_in;
   logic [ID_BITS-1:0] pid_ff, pid_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      step_ff, step_in;
   logic               hit_ff, hit_in;
   logic [ID_BITS-1:0] res_pid_ff, res_pid_in;
   logic               res_found_ff, res_found_in;
   logic               res_ready_ff, res_ready_in;
   status_type         res_status_ff, res_status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ID_BITS-1:0] rsp_pid_ff, rsp_pid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic               rsp_ready_ff, rsp_ready_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic               out_free;
   logic               match;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign match    = (head_id == pid_ff) && !hit_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               case (op_type'(req_tdata[1:0]))
                  OP_ADD:  state_in = S_ADD;
                  OP_PICK: state_in = S_DROP;
                  default: state_in = S_SCAN;
               endcase
            end
         end
         S_ADD: state_in = S_DONE;
         S_DROP: begin
            if (count_ff == '0 || head_ready) begin
               state_in = S_DONE;
            end
         end
         S_SCAN: begin
            if (step_ff == count_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_tready    = (state_ff == S_IDLE);
      cell_op       = CELL_HOLD;
      op_in         = op_ff;
      pid_in        = pid_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      hit_in        = hit_ff;
      res_pid_in    = res_pid_ff;
      res_found_in  = res_found_ff;
      res_ready_in  = res_ready_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_pid_in    = rsp_pid_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_ready_in  = rsp_ready_ff;
      rsp_status_in = rsp_status_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in         = op_type'(req_tdata[1:0]);
               pid_in        = req_tdata[2 +: ID_BITS];
               step_in       = '0;
               hit_in        = 1'b0;
               res_pid_in    = '0;
               res_found_in  = 1'b0;
               res_ready_in  = 1'b0;
               res_status_in = ST_MISS;
            end
         end
         S_ADD: begin
            if (count_ff < CW'(QUEUE_DEPTH)) begin
               cell_op       = CELL_WRITE;
               count_in      = count_ff + 1'b1;
               res_status_in = ST_OK;
            end else begin
               res_status_in = ST_FULL;
            end
         end
         S_DROP: begin
            if (count_ff != '0) begin
               if (!head_ready) begin
                  cell_op  = CELL_SHIFT;
                  count_in = count_ff - 1'b1;
               end else begin
                  cell_op       = CELL_ROTATE;
                  res_pid_in    = head_id;
                  res_found_in  = 1'b1;
                  res_ready_in  = 1'b1;
                  res_status_in = ST_OK;
               end
            end
         end
         S_SCAN: begin
            if (step_ff != count_ff) begin
               step_in = step_ff + 1'b1;
               cell_op = (match && op_ff == OP_UNREADY) ? CELL_ROTATE_CLR : CELL_ROTATE;
               if (match) begin
                  hit_in        = 1'b1;
                  res_pid_in    = head_id;
                  res_found_in  = 1'b1;
                  res_ready_in  = (op_ff == OP_UNREADY) ? 1'b0 : head_ready;
                  res_status_in = ST_OK;
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_pid_in    = res_pid_ff;
               rsp_found_in  = res_found_ff;
               rsp_ready_in  = res_ready_ff;
               rsp_status_in = res_status_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      pid_ff        <= pid_in;
      step_ff       <= step_in;
      hit_ff        <= hit_in;
      res_pid_ff    <= res_pid_in;
      res_found_ff  <= res_found_in;
      res_ready_ff  <= res_ready_in;
      res_status_ff <= res_status_in;
      rsp_pid_ff    <= rsp_pid_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_ready_ff  <= rsp_ready_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = OUT_W'({rsp_status_ff, rsp_ready_ff, rsp_found_ff, rsp_pid_ff});
   assign entry_count = count_ff;
   assign write_id    = pid_ff;

   `RRQ_NEVER(count_in_range, count_ff > CW'(QUEUE_DEPTH), "entry count exceeds queue depth")
   `RRQ_ASSERT(accept_leaves_idle, (req_tvalid && req_tready) |=> (state_ff != S_IDLE), "accepted transfer did not start work")
   `RRQ_ASSERT(count_moves_by_one, (count_ff == $past(count_ff)) || (count_ff == $past(count_ff) + 1'b1) || (count_ff + 1'b1 == $past(count_ff)), "entry count jumped")
   `RRQ_ASSERT(full_add_keeps_count, (state_ff == S_ADD && count_ff == CW'(QUEUE_DEPTH)) |=> (count_ff == CW'(QUEUE_DEPTH)), "add to a full queue changed the count")

endmodule

FILE: sv/round_robin_run_queue.sv
// Round-robin run queue of task identifiers held in a chain of cells, cell zero being the
// head. A request transfer carries op in req_tdata[1:0] and task_pid above it; each request
// gives one response transfer. Pick drops each not-ready entry it finds at the head, and
// lookup or mark-not-ready walks the whole queue once past cell zero, the chain rotating by
// one position per cycle. When the response register is loaded the controller returns to
// idle and then accepts the next request. A new request is accepted while the previous
// response still waits to be taken, but its own response then waits in the final step until
// the output register is free.
`timescale 1ns / 1ps
module round_robin_run_queue import rrq_pkg::*; #(
   parameter int QUEUE_DEPTH = RRQ_QUEUE_DEPTH,
   parameter int ID_BITS     = RRQ_ID_BITS,
   localparam int CW         = $clog2(QUEUE_DEPTH + 1),
   localparam int IN_W       = ((2 + ID_BITS + 7) / 8) * 8,
   localparam int OUT_W      = ((ID_BITS + 4 + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [IN_W-1:0]  req_tdata,   // op, task_pid
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [OUT_W-1:0] rsp_tdata    // result_pid, found, entry_ready, status
);

   logic [ID_BITS-1:0] cell_id    [QUEUE_DEPTH];
   logic               cell_ready [QUEUE_DEPTH];
   cell_op_type        cell_op;
   logic [CW-1:0]      entry_count;
   logic [ID_BITS-1:0] write_id;

   rrq_ctrl #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .ID_BITS    (ID_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .head_id    (cell_id[0]),
      .head_ready (cell_ready[0]),
      .cell_op    (cell_op),
      .entry_count(entry_count),
      .write_id   (write_id)
   );

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic [ID_BITS-1:0] next_id;
      logic               next_ready;

      if (i == QUEUE_DEPTH - 1) begin : g_end
         assign next_id    = '0;
         assign next_ready = 1'b0;
      end else begin : g_mid
         assign next_id    = cell_id[i+1];
         assign next_ready = cell_ready[i+1];
      end

      rrq_cell #(
         .ID_BITS(ID_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_op   (cell_op),
         .sel_write (entry_count == CW'(i)),
         .sel_last  (entry_count == CW'(i + 1)),
         .write_id  (write_id),
         .next_id   (next_id),
         .next_ready(next_ready),
         .head_id   (cell_id[0]),
         .head_ready(cell_ready[0]),
         .id_out    (cell_id[i]),
         .ready_out (cell_ready[i])
      );
   end

endmodule
